>>> rtl/nsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nsh_pkg;

  // period in microseconds: 65535 * 1000 fits in 26 bits
  localparam int PW = 26;
  localparam logic [PW-1:0] MS_TO_US = PW'(1000);

  localparam logic [6:0] HB_BOOT        = 7'd0;
  localparam logic [6:0] HB_STOPPED     = 7'd4;
  localparam logic [6:0] HB_OPERATIONAL = 7'd5;
  localparam logic [6:0] HB_PREOP       = 7'd127;
  localparam logic [3:0] HB_ID_HI       = 4'hE;

  localparam logic [10:0] NMT_ID  = 11'h000;
  localparam logic [10:0] SYNC_ID = 11'h080;
  localparam logic [7:0]  NMT_BROADCAST = 8'd0;

  localparam logic [7:0] CS_START    = 8'd1;
  localparam logic [7:0] CS_STOP     = 8'd2;
  localparam logic [7:0] CS_PREOP    = 8'd128;
  localparam logic [7:0] CS_RST_NODE = 8'd129;
  localparam logic [7:0] CS_RST_COMM = 8'd130;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] ROUTE_IGNORED = 2'd0;
  localparam logic [1:0] ROUTE_NMT     = 2'd1;
  localparam logic [1:0] ROUTE_SYNC    = 2'd2;
  localparam logic [1:0] ROUTE_PASS    = 2'd3;

  localparam logic [1:0] CFG_NODE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_HB_PERIOD    = 2'd1;
  localparam logic [1:0] CFG_DICT_READY   = 2'd2;

  // micro-ops
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_DECODE   = 4'd2;
  localparam logic [3:0] OP_BOOT     = 4'd3;
  localparam logic [3:0] OP_GO       = 4'd4;
  localparam logic [3:0] OP_CLR      = 4'd5;
  localparam logic [3:0] OP_ARM      = 4'd6;
  localparam logic [3:0] OP_DIV_INIT = 4'd7;
  localparam logic [3:0] OP_DIV_STEP = 4'd8;
  localparam logic [3:0] OP_SUB_REM  = 4'd9;
  localparam logic [3:0] OP_ADD_P    = 4'd10;
  localparam logic [3:0] OP_EMIT     = 4'd11;

  // jump conditions
  localparam logic [3:0] C_NEVER    = 4'd0;
  localparam logic [3:0] C_ALWAYS   = 4'd1;
  localparam logic [3:0] C_NO_INPUT = 4'd2;
  localparam logic [3:0] C_START_OK = 4'd3;
  localparam logic [3:0] C_NMT_ACT  = 4'd4;
  localparam logic [3:0] C_NMT_RST  = 4'd5;
  localparam logic [3:0] C_TICK_OFF = 4'd6;
  localparam logic [3:0] C_TICK_ARM = 4'd7;
  localparam logic [3:0] C_TICK_DUE = 4'd8;
  localparam logic [3:0] C_REM_MORE = 4'd9;
  localparam logic [3:0] C_OUT_FREE = 4'd10;

  localparam int UPC_W = 5;
  localparam logic [UPC_W-1:0] S_IDLE     = 5'd0;
  localparam logic [UPC_W-1:0] S_DECODE   = 5'd1;
  localparam logic [UPC_W-1:0] S_CHK_NMT  = 5'd2;
  localparam logic [UPC_W-1:0] S_CHK_RST  = 5'd3;
  localparam logic [UPC_W-1:0] S_CHK_OFF  = 5'd4;
  localparam logic [UPC_W-1:0] S_CHK_ARM  = 5'd5;
  localparam logic [UPC_W-1:0] S_CHK_DUE  = 5'd6;
  localparam logic [UPC_W-1:0] S_NONE     = 5'd7;
  localparam logic [UPC_W-1:0] S_BOOT     = 5'd8;
  localparam logic [UPC_W-1:0] S_GO       = 5'd9;
  localparam logic [UPC_W-1:0] S_CLR      = 5'd10;
  localparam logic [UPC_W-1:0] S_ARM      = 5'd11;
  localparam logic [UPC_W-1:0] S_DIV      = 5'd12;
  localparam logic [UPC_W-1:0] S_DIV_LOOP = 5'd13;
  localparam logic [UPC_W-1:0] S_SUB_REM  = 5'd14;
  localparam logic [UPC_W-1:0] S_ADD_P    = 5'd15;
  localparam logic [UPC_W-1:0] S_EMIT     = 5'd16;
  localparam logic [UPC_W-1:0] S_EMIT_WT  = 5'd17;

  typedef struct packed {
    logic [3:0]       op;
    logic [3:0]       cond;
    logic [UPC_W-1:0] tgt;
  } ucw_t;

  typedef struct packed {
    logic in_valid;
    logic start_ok;
    logic nmt_act;
    logic nmt_rst;
    logic tick_off;
    logic tick_arm;
    logic tick_due;
    logic rem_more;
    logic out_free;
  } cflags_t;

  typedef struct packed {
    logic start;
    logic step;
  } rem_ctl_t;

  function automatic ucw_t ucode(input logic [UPC_W-1:0] a);
    ucw_t w;
    unique case (a)
      S_IDLE:     w = '{OP_LOAD,     C_NO_INPUT, S_IDLE};
      S_DECODE:   w = '{OP_DECODE,   C_START_OK, S_BOOT};
      S_CHK_NMT:  w = '{OP_NOP,      C_NMT_ACT,  S_GO};
      S_CHK_RST:  w = '{OP_NOP,      C_NMT_RST,  S_BOOT};
      S_CHK_OFF:  w = '{OP_NOP,      C_TICK_OFF, S_CLR};
      S_CHK_ARM:  w = '{OP_NOP,      C_TICK_ARM, S_ARM};
      S_CHK_DUE:  w = '{OP_NOP,      C_TICK_DUE, S_DIV};
      S_NONE:     w = '{OP_NOP,      C_ALWAYS,   S_EMIT};
      S_BOOT:     w = '{OP_BOOT,     C_ALWAYS,   S_EMIT};
      S_GO:       w = '{OP_GO,       C_ALWAYS,   S_EMIT};
      S_CLR:      w = '{OP_CLR,      C_ALWAYS,   S_EMIT};
      S_ARM:      w = '{OP_ARM,      C_ALWAYS,   S_EMIT};
      S_DIV:      w = '{OP_DIV_INIT, C_NEVER,    S_IDLE};
      S_DIV_LOOP: w = '{OP_DIV_STEP, C_REM_MORE, S_DIV_LOOP};
      S_SUB_REM:  w = '{OP_SUB_REM,  C_NEVER,    S_IDLE};
      S_ADD_P:    w = '{OP_ADD_P,    C_ALWAYS,   S_EMIT};
      S_EMIT:     w = '{OP_EMIT,     C_OUT_FREE, S_IDLE};
      S_EMIT_WT:  w = '{OP_NOP,      C_ALWAYS,   S_EMIT};
      default:    w = '{OP_NOP,      C_ALWAYS,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/nsh_useq.sv
`timescale 1ns / 1ps
`default_nettype none

module nsh_useq
  import nsh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cflags_t    flags,
  output logic [3:0]      op,
  output logic            idle
);

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  ucw_t             cw;
  logic             take;

  assign cw   = ucode(upc_r);
  assign op   = cw.op;
  assign idle = (upc_r == S_IDLE);

  always_comb begin
    unique case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = !flags.in_valid;
      C_START_OK: take = flags.start_ok;
      C_NMT_ACT:  take = flags.nmt_act;
      C_NMT_RST:  take = flags.nmt_rst;
      C_TICK_OFF: take = flags.tick_off;
      C_TICK_ARM: take = flags.tick_arm;
      C_TICK_DUE: take = flags.tick_due;
      C_REM_MORE: take = flags.rem_more;
      C_OUT_FREE: take = flags.out_free;
      default:    take = 1'b0;
    endcase
    upc_nxt = take ? cw.tgt : upc_r + UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nsh_rem.sv
`timescale 1ns / 1ps
`default_nettype none

module nsh_rem
  import nsh_pkg::*;
#(
  parameter int TIME_BITS = 48
)(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rem_ctl_t             ctl,
  input  wire logic [TIME_BITS-1:0] dividend,
  input  wire logic [PW-1:0]        divisor,
  output logic [PW-1:0]             rem,
  output logic                      more
);

  localparam int CW = $clog2(TIME_BITS + 1);

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0] dsh_r, dsh_nxt;
  logic [PW-1:0]        rem_r, rem_nxt;
  logic [PW:0]          trial;
  logic [PW:0]          diff;

  assign trial = {rem_r, dsh_r[TIME_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign rem   = rem_r;
  assign more  = (cnt_r != CW'(1));

  // restoring division, one quotient bit per beat while ctl.step is high; only the remainder is kept
  always_comb begin
    cnt_nxt = cnt_r;
    dsh_nxt = dsh_r;
    rem_nxt = rem_r;
    if (ctl.start) begin
      cnt_nxt = CW'(TIME_BITS);
      dsh_nxt = dividend;
      rem_nxt = '0;
    end else if (ctl.step) begin
      cnt_nxt = cnt_r - CW'(1);
      dsh_nxt = {dsh_r[TIME_BITS-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? diff[PW-1:0] : trial[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dsh_r <= dsh_nxt;
    rem_r <= rem_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/nmt_slave_with_heartbeat.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake            payload
// in       to block   in_valid / in_stall  cmd, now_us, can_id, flags, size, two bytes
// out      from block out_valid / out_stall ok, route, heartbeat valid/id/code, state
// cfg      to block   cfg_we               cfg_index, cfg_data
//
// Per item: load, decode (a valid start goes to boot), then checks for NMT state
// change, NMT reset, heartbeats off, arming, due heartbeat; then action and emit. A due
// heartbeat runs the remainder unit (one bit a beat). One microcode step per cycle.
// in_stall is low only at the idle step. A result waits in the output register while
// the next item runs; if that register is still full, emit retries via a wait step.
// Reset is synchronous: node 1, heartbeats off, dictionary not ready, node not started.

module nmt_slave_with_heartbeat
  import nsh_pkg::*;
#(
  parameter int TIME_BITS = 48
)(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_cmd,
  input  wire logic [TIME_BITS-1:0] in_now_us,
  input  wire logic [10:0]          in_can_id,
  input  wire logic                 in_is_extended,
  input  wire logic                 in_is_remote,
  input  wire logic                 in_is_fd,
  input  wire logic [6:0]           in_payload_size,
  input  wire logic [7:0]           in_first_byte,
  input  wire logic [7:0]           in_second_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_ok,
  output logic [1:0]                out_route,
  output logic                      out_heartbeat_valid,
  output logic [10:0]               out_heartbeat_id,
  output logic [6:0]                out_heartbeat_code,
  output logic [6:0]                out_current_state
);

  logic [6:0]  node_r, node_nxt;
  logic [15:0] period_r, period_nxt;
  logic        ready_r, ready_nxt;
  logic [PW-1:0] p_us_r, p_us_nxt;

  logic [1:0]           cmd_r, cmd_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [10:0]          id_r, id_nxt;
  logic                 ext_r, ext_nxt;
  logic                 rtr_r, rtr_nxt;
  logic                 fd_r, fd_nxt;
  logic [6:0]           size_r, size_nxt;
  logic [7:0]           cs_r, cs_nxt;
  logic [7:0]           tgt_r, tgt_nxt;

  logic                 running_r, running_nxt;
  logic [6:0]           mode_r, mode_nxt;
  logic [TIME_BITS-1:0] next_r, next_nxt;

  logic       res_ok_r, res_ok_nxt;
  logic [1:0] res_route_r, res_route_nxt;
  logic       hb_v_r, hb_v_nxt;
  logic [6:0] hb_code_r, hb_code_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r, out_ok_nxt;
  logic [1:0]  out_route_r, out_route_nxt;
  logic        out_hbv_r, out_hbv_nxt;
  logic [10:0] out_hbid_r, out_hbid_nxt;
  logic [6:0]  out_hbc_r, out_hbc_nxt;
  logic [6:0]  out_st_r, out_st_nxt;

  logic [3:0] op;
  logic       idle;
  cflags_t    flags;
  rem_ctl_t   rem_ctl;
  logic [PW-1:0] rem;
  logic          rem_more;

  logic rx_ok, is_nmt, is_sync, for_me, start_ok, tick;
  logic go_known;
  logic [6:0] go_mode;
  logic [TIME_BITS-1:0] p_ext, sched;
  logic out_free;

  assign p_ext    = TIME_BITS'(p_us_r);
  assign sched    = (period_r == 16'd0) ? '0 : now_r + p_ext;
  assign out_free = !out_valid_r || !out_stall;

  assign rx_ok    = (cmd_r == CMD_FRAME) && running_r && !ext_r && !rtr_r;
  assign is_nmt   = rx_ok && (id_r == NMT_ID) && !fd_r && (size_r == 7'd2);
  assign is_sync  = rx_ok && !is_nmt && (id_r == SYNC_ID) && !fd_r && (size_r <= 7'd1);
  assign for_me   = (tgt_r == NMT_BROADCAST) || (tgt_r == {1'b0, node_r});
  assign start_ok = (cmd_r == CMD_START) && !running_r && (node_r != 7'd0) && ready_r;
  assign tick     = (cmd_r == CMD_TICK) && running_r;

  always_comb begin
    unique case (cs_r)
      CS_START: begin
        go_known = 1'b1;
        go_mode  = HB_OPERATIONAL;
      end
      CS_STOP: begin
        go_known = 1'b1;
        go_mode  = HB_STOPPED;
      end
      CS_PREOP: begin
        go_known = 1'b1;
        go_mode  = HB_PREOP;
      end
      default: begin
        go_known = 1'b0;
        go_mode  = HB_PREOP;
      end
    endcase
  end

  always_comb begin
    flags.in_valid = in_valid;
    flags.start_ok = start_ok;
    flags.nmt_act  = is_nmt && for_me && go_known;
    flags.nmt_rst  = is_nmt && for_me && ((cs_r == CS_RST_NODE) || (cs_r == CS_RST_COMM));
    flags.tick_off = tick && (period_r == 16'd0);
    flags.tick_arm = tick && (period_r != 16'd0) && (next_r == '0);
    flags.tick_due = tick && (period_r != 16'd0) && (next_r != '0) && (now_r >= next_r);
    flags.rem_more = rem_more;
    flags.out_free = out_free;
    rem_ctl.start  = (op == OP_DIV_INIT);
    rem_ctl.step   = (op == OP_DIV_STEP);
  end

  nsh_useq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op),
    .idle  (idle)
  );

  nsh_rem #(
    .TIME_BITS (TIME_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rem_ctl),
    .dividend (now_r - next_r),
    .divisor  (p_us_r),
    .rem      (rem),
    .more     (rem_more)
  );

  assign in_stall = !idle;

  always_comb begin
    node_nxt      = node_r;
    period_nxt    = period_r;
    ready_nxt     = ready_r;
    p_us_nxt      = PW'(period_r) * MS_TO_US;
    cmd_nxt       = cmd_r;
    now_nxt       = now_r;
    id_nxt        = id_r;
    ext_nxt       = ext_r;
    rtr_nxt       = rtr_r;
    fd_nxt        = fd_r;
    size_nxt      = size_r;
    cs_nxt        = cs_r;
    tgt_nxt       = tgt_r;
    running_nxt   = running_r;
    mode_nxt      = mode_r;
    next_nxt      = next_r;
    res_ok_nxt    = res_ok_r;
    res_route_nxt = res_route_r;
    hb_v_nxt      = hb_v_r;
    hb_code_nxt   = hb_code_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_route_nxt = out_route_r;
    out_hbv_nxt   = out_hbv_r;
    out_hbid_nxt  = out_hbid_r;
    out_hbc_nxt   = out_hbc_r;
    out_st_nxt    = out_st_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ADDRESS: node_nxt   = cfg_data[6:0];
        CFG_HB_PERIOD:    period_nxt = cfg_data;
        CFG_DICT_READY:   ready_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    unique case (op)
      OP_LOAD: begin
        if (in_valid) begin
          cmd_nxt  = in_cmd;
          now_nxt  = in_now_us;
          id_nxt   = in_can_id;
          ext_nxt  = in_is_extended;
          rtr_nxt  = in_is_remote;
          fd_nxt   = in_is_fd;
          size_nxt = in_payload_size;
          cs_nxt   = in_first_byte;
          tgt_nxt  = in_second_byte;
        end
      end
      OP_DECODE: begin
        res_ok_nxt    = start_ok || is_nmt || is_sync;
        res_route_nxt = !rx_ok  ? ROUTE_IGNORED :
                        is_nmt  ? ROUTE_NMT :
                        is_sync ? ROUTE_SYNC : ROUTE_PASS;
        hb_v_nxt      = 1'b0;
        hb_code_nxt   = HB_BOOT;
      end
      OP_BOOT: begin
        running_nxt = 1'b1;
        mode_nxt    = HB_PREOP;
        hb_v_nxt    = 1'b1;
        hb_code_nxt = HB_BOOT;
        next_nxt    = sched;
      end
      OP_GO: begin
        mode_nxt    = go_mode;
        hb_v_nxt    = 1'b1;
        hb_code_nxt = go_mode;
        next_nxt    = sched;
      end
      OP_CLR:      next_nxt = '0;
      OP_ARM:      next_nxt = now_r + p_ext;
      OP_DIV_INIT: begin
        hb_v_nxt    = 1'b1;
        hb_code_nxt = mode_r;
      end
      // new deadline = now - ((now - next) mod p) + p
      OP_SUB_REM:  next_nxt = now_r - TIME_BITS'(rem);
      OP_ADD_P:    next_nxt = next_r + p_ext;
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_route_nxt = res_route_r;
          out_hbv_nxt   = hb_v_r;
          out_hbid_nxt  = hb_v_r ? {HB_ID_HI, node_r} : 11'd0;
          out_hbc_nxt   = hb_code_r;
          out_st_nxt    = mode_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r      <= 7'd1;
      period_r    <= 16'd0;
      ready_r     <= 1'b0;
      p_us_r      <= '0;
      running_r   <= 1'b0;
      mode_r      <= HB_BOOT;
      next_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      node_r      <= node_nxt;
      period_r    <= period_nxt;
      ready_r     <= ready_nxt;
      p_us_r      <= p_us_nxt;
      running_r   <= running_nxt;
      mode_r      <= mode_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    now_r       <= now_nxt;
    id_r        <= id_nxt;
    ext_r       <= ext_nxt;
    rtr_r       <= rtr_nxt;
    fd_r        <= fd_nxt;
    size_r      <= size_nxt;
    cs_r        <= cs_nxt;
    tgt_r       <= tgt_nxt;
    res_ok_r    <= res_ok_nxt;
    res_route_r <= res_route_nxt;
    hb_v_r      <= hb_v_nxt;
    hb_code_r   <= hb_code_nxt;
    out_ok_r    <= out_ok_nxt;
    out_route_r <= out_route_nxt;
    out_hbv_r   <= out_hbv_nxt;
    out_hbid_r  <= out_hbid_nxt;
    out_hbc_r   <= out_hbc_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_ok              = out_ok_r;
  assign out_route           = out_route_r;
  assign out_heartbeat_valid = out_hbv_r;
  assign out_heartbeat_id    = out_hbid_r;
  assign out_heartbeat_code  = out_hbc_r;
  assign out_current_state   = out_st_r;

  a_stopped_is_boot: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (mode_r == HB_BOOT))
    else $error("mode left boot while node not running");

  a_running_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |=> running_r)
    else $error("node dropped out of running");

  a_hb_id_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hbv_r) |-> (out_hbid_r[10:7] == HB_ID_HI))
    else $error("heartbeat id outside 0x700 range");

  a_no_hb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hbv_r) |-> ((out_hbid_r == 11'd0) && (out_hbc_r == HB_BOOT)))
    else $error("heartbeat fields set without heartbeat");

endmodule

`default_nettype wire

>>> dv/nmt_slave_checker.sv
`timescale 1ns / 1ps

module nmt_slave_checker
  import nsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [47:0] in_now_us,
  input  logic [10:0] in_can_id,
  input  logic        in_is_extended,
  input  logic        in_is_remote,
  input  logic        in_is_fd,
  input  logic [6:0]  in_payload_size,
  input  logic [7:0]  in_first_byte,
  input  logic [7:0]  in_second_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_ok,
  input  logic [1:0]  out_route,
  input  logic        out_heartbeat_valid,
  input  logic [10:0] out_heartbeat_id,
  input  logic [6:0]  out_heartbeat_code,
  input  logic [6:0]  out_current_state,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic        ok;
    logic [1:0]  route;
    logic        hb_valid;
    logic [10:0] hb_id;
    logic [6:0]  hb_code;
    logic [6:0]  state;
  } nmt_status_t;

  logic [6:0]  node_addr;
  logic [15:0] period_ms;
  logic        dict_ready;
  logic        started;
  logic [6:0]  mode;
  logic [47:0] deadline;
  logic        hb_fire;
  logic [6:0]  hb_state;
  nmt_status_t want;
  nmt_status_t expected_status[$];

  function automatic logic [47:0] hb_span_us();
    return 48'(period_ms) * 48'(MS_TO_US);
  endfunction

  function automatic void enter_mode(input logic [6:0] m, input logic [47:0] now,
                                     input logic announce);
    mode = m;
    deadline = (period_ms == 0) ? '0 : now + hb_span_us();
    if (announce) begin
      hb_fire = 1'b1;
      hb_state = m;
    end
  endfunction

  function automatic nmt_status_t nmt_step(
    input logic [1:0]  cmd,
    input logic [47:0] now,
    input logic [10:0] id,
    input logic        ext,
    input logic        rem,
    input logic        fd,
    input logic [6:0]  size,
    input logic [7:0]  cs,
    input logic [7:0]  target
  );
    nmt_status_t r;
    logic [47:0] p;
    logic [63:0] laps;
    r = '0;
    r.route = ROUTE_IGNORED;
    hb_fire = 1'b0;
    hb_state = '0;
    p = hb_span_us();
    case (cmd)
      CMD_START: begin
        if (!started && node_addr != 0 && dict_ready) begin
          started = 1'b1;
          hb_fire = 1'b1;
          hb_state = HB_BOOT;
          enter_mode(HB_PREOP, now, 1'b0);
          r.ok = 1'b1;
        end
      end
      CMD_FRAME: begin
        if (started && !ext && !rem) begin
          if (id == NMT_ID && !fd && size == 7'd2) begin
            r.ok = 1'b1;
            r.route = ROUTE_NMT;
            if (target == NMT_BROADCAST || target == {1'b0, node_addr}) begin
              case (cs)
                CS_START: enter_mode(HB_OPERATIONAL, now, 1'b1);
                CS_STOP:  enter_mode(HB_STOPPED, now, 1'b1);
                CS_PREOP: enter_mode(HB_PREOP, now, 1'b1);
                CS_RST_NODE, CS_RST_COMM: begin
                  hb_fire = 1'b1;
                  hb_state = HB_BOOT;
                  enter_mode(HB_PREOP, now, 1'b0);
                end
                default: ;
              endcase
            end
          end else if (id == SYNC_ID && !fd && size <= 7'd1) begin
            r.ok = 1'b1;
            r.route = ROUTE_SYNC;
          end else begin
            r.route = ROUTE_PASS;
          end
        end
      end
      CMD_TICK: begin
        if (started) begin
          if (period_ms == 0) begin
            deadline = '0;
          end else if (deadline == 0) begin
            deadline = now + p;
          end else if (now >= deadline) begin
            // jump past now by whole periods
            laps = 64'((now - deadline) / p) + 64'd1;
            hb_fire = 1'b1;
            hb_state = mode;
            deadline = 48'(64'(deadline) + laps * 64'(p));
          end
        end
      end
      default: ;
    endcase
    r.hb_valid = hb_fire;
    r.hb_id = hb_fire ? {HB_ID_HI, node_addr} : '0;
    r.hb_code = hb_fire ? hb_state : '0;
    r.state = mode;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [10:0] want_v,
                             input logic [10:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      node_addr = 7'd1;
      period_ms = '0;
      dict_ready = 1'b0;
      started = 1'b0;
      mode = HB_BOOT;
      deadline = '0;
      expected_status.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_ADDRESS: node_addr = cfg_data[6:0];
          CFG_HB_PERIOD:    period_ms = cfg_data;
          CFG_DICT_READY:   dict_ready = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("result beat with no item pending");
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("ok", 11'(want.ok), 11'(out_ok));
          check_field("route", 11'(want.route), 11'(out_route));
          check_field("heartbeat_valid", 11'(want.hb_valid), 11'(out_heartbeat_valid));
          check_field("heartbeat_id", want.hb_id, out_heartbeat_id);
          check_field("heartbeat_code", 11'(want.hb_code), 11'(out_heartbeat_code));
          check_field("current_state", 11'(want.state), 11'(out_current_state));
        end
      end
      if (in_valid && !in_stall) begin
        expected_status.push_back(nmt_step(in_cmd, in_now_us, in_can_id, in_is_extended,
                                           in_is_remote, in_is_fd, in_payload_size,
                                           in_first_byte, in_second_byte));
      end
      outstanding <= expected_status.size();
    end
  end

endmodule

>>> dv/tb_nmt_slave_with_heartbeat.sv
`timescale 1ns / 1ps

module tb_nmt_slave_with_heartbeat;
  import nsh_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [47:0] TIME_TOP    = '1;
  localparam logic [47:0] P_MAX_US    = 48'd65_535_000;
  localparam logic [47:0] T_NMT       = 48'd1_000_000_000;
  localparam int          PHASE_ITEMS = 250;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [47:0] in_now_us;
  logic [10:0] in_can_id;
  logic        in_is_extended;
  logic        in_is_remote;
  logic        in_is_fd;
  logic [6:0]  in_payload_size;
  logic [7:0]  in_first_byte;
  logic [7:0]  in_second_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_ok;
  logic [1:0]  out_route;
  logic        out_heartbeat_valid;
  logic [10:0] out_heartbeat_id;
  logic [6:0]  out_heartbeat_code;
  logic [6:0]  out_current_state;
  int          fail_count;
  int          outstanding;

  int          send_idle_pct;
  int          recv_idle_pct;
  logic        squeeze;
  logic [6:0]  node_cfg;
  logic [15:0] period_cfg;
  logic [47:0] clock_us;

  nmt_slave_with_heartbeat DUT (.*);

  nmt_slave_checker status_check (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("tb_nmt_slave_with_heartbeat: done, errors");
    $finish;
  end

  // receiver: random stall, plus one long hold-off once squeeze is raised
  initial begin
    int   held_cycles;
    logic squeezed;
    squeezed = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        for (held_cycles = 0; held_cycles < 400; held_cycles++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        squeezed = 1'b1;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic offer(
    input logic [1:0]  c,
    input logic [47:0] t,
    input logic [10:0] id,
    input logic        ext,
    input logic        rem,
    input logic        fd,
    input logic [6:0]  sz,
    input logic [7:0]  b0,
    input logic [7:0]  b1
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_now_us <= t;
    in_can_id <= id;
    in_is_extended <= ext;
    in_is_remote <= rem;
    in_is_fd <= fd;
    in_payload_size <= sz;
    in_first_byte <= b0;
    in_second_byte <= b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_config(input logic [6:0] node, input logic [15:0] period,
                            input logic ready);
    node_cfg = node;
    period_cfg = period;
    cfg_we <= 1'b1;
    cfg_index <= CFG_NODE_ADDRESS;
    cfg_data <= {9'($urandom), node};
    @(posedge clk);
    cfg_index <= CFG_HB_PERIOD;
    cfg_data <= period;
    @(posedge clk);
    cfg_index <= CFG_DICT_READY;
    cfg_data <= {15'($urandom), ready};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    logic [1:0]  c;
    logic [10:0] id;
    logic        ext;
    logic        rem;
    logic        fd;
    logic [6:0]  sz;
    logic [7:0]  cs;
    logic [7:0]  tgt;
    int          pick;
    int unsigned span;
    span = 32'(period_cfg) * 2000 + 1000;
    pick = $urandom_range(99);
    if (pick < 3) begin
      clock_us = {16'($urandom), 32'($urandom)};
    end else if (pick < 5) begin
      clock_us = TIME_TOP - 48'($urandom_range(span, 0));
    end else if (pick >= 20) begin
      clock_us = clock_us + 48'($urandom_range(span, 0));
    end
    c = CMD_FRAME;
    id = 11'($urandom);
    ext = 1'b0;
    rem = 1'b0;
    fd = 1'b0;
    sz = 7'd2;
    cs = 8'($urandom);
    tgt = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 38) begin
      c = CMD_TICK;
      ext = 1'($urandom);
      rem = 1'($urandom);
      fd = 1'($urandom);
      sz = 7'($urandom_range(64, 0));
    end else if (pick < 72) begin
      id = NMT_ID;
      case ($urandom_range(5))
        0: cs = CS_START;
        1: cs = CS_STOP;
        2: cs = CS_PREOP;
        3: cs = CS_RST_NODE;
        4: cs = CS_RST_COMM;
        default: ;
      endcase
      case ($urandom_range(2))
        0: tgt = NMT_BROADCAST;
        1: tgt = {1'b0, node_cfg};
        default: ;
      endcase
    end else if (pick < 80) begin
      id = SYNC_ID;
      sz = 7'($urandom_range(2, 0));
      fd = ($urandom_range(9) == 0);
    end else if (pick < 94) begin
      case ($urandom_range(3))
        0: id = NMT_ID;
        1: id = SYNC_ID;
        default: ;
      endcase
      ext = 1'($urandom);
      rem = 1'($urandom);
      fd = 1'($urandom);
      sz = 7'($urandom_range(64, 0));
    end else if (pick < 97) begin
      c = CMD_START;
    end else begin
      c = CMD_UNUSED;
    end
    offer(c, clock_us, id, ext, rem, fd, sz, cs, tgt);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_NODE_ADDRESS;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_cmd <= CMD_START;
    in_now_us <= '0;
    in_can_id <= '0;
    in_is_extended <= 1'b0;
    in_is_remote <= 1'b0;
    in_is_fd <= 1'b0;
    in_payload_size <= '0;
    in_first_byte <= '0;
    in_second_byte <= '0;
    squeeze <= 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 65;
    node_cfg = 7'd1;
    period_cfg = '0;
    clock_us = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: dictionary not ready, node not started
    offer(CMD_START, 48'd0, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, CS_START, NMT_BROADCAST);
    offer(CMD_FRAME, 48'd10, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, CS_START, NMT_BROADCAST);
    offer(CMD_TICK, 48'd100, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0);
    offer(CMD_UNUSED, TIME_TOP, 11'h7FF, 1'b1, 1'b1, 1'b1, 7'd64, 8'hFF, 8'hFF);
    drain();
    set_config(7'd0, 16'hFFFF, 1'b1);
    offer(CMD_START, 48'd7, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, CS_START, NMT_BROADCAST);
    drain();
    set_config(7'd127, 16'hFFFF, 1'b1);
    // deadline sum wraps to zero: stays unscheduled
    offer(CMD_START, TIME_TOP - P_MAX_US + 48'd1, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, 8'd0, 8'd0);
    offer(CMD_START, 48'd1, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, 8'd0, 8'd0);
    offer(CMD_TICK, 48'd5, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0);
    offer(CMD_TICK, 48'd4 + P_MAX_US, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0);
    offer(CMD_TICK, 48'd5 + P_MAX_US, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0);
    offer(CMD_TICK, 48'd8 + 48'd12 * P_MAX_US, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0);
    offer(CMD_FRAME, T_NMT, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, CS_START, NMT_BROADCAST);
    offer(CMD_FRAME, T_NMT, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, CS_STOP, 8'd127);
    offer(CMD_FRAME, T_NMT, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, CS_PREOP, 8'd5);
    offer(CMD_FRAME, T_NMT, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, CS_PREOP, 8'd127);
    offer(CMD_FRAME, T_NMT, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, CS_RST_NODE, NMT_BROADCAST);
    offer(CMD_FRAME, T_NMT, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, CS_RST_COMM, 8'd127);
    offer(CMD_FRAME, T_NMT, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd2, 8'hFF, NMT_BROADCAST);
    offer(CMD_FRAME, T_NMT, NMT_ID, 1'b0, 1'b0, 1'b1, 7'd2, CS_START, NMT_BROADCAST);
    offer(CMD_FRAME, T_NMT, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd3, CS_START, NMT_BROADCAST);
    offer(CMD_FRAME, T_NMT, SYNC_ID, 1'b0, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0);
    offer(CMD_FRAME, T_NMT, SYNC_ID, 1'b0, 1'b0, 1'b0, 7'd1, 8'd0, 8'd0);
    offer(CMD_FRAME, T_NMT, 11'h7FF, 1'b1, 1'b0, 1'b1, 7'd64, 8'hFF, 8'hFF);
    offer(CMD_FRAME, T_NMT, NMT_ID, 1'b0, 1'b1, 1'b0, 7'd2, CS_START, NMT_BROADCAST);
    offer(CMD_TICK, TIME_TOP, NMT_ID, 1'b0, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0);
    clock_us = TIME_TOP;

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_config(7'd42, 16'd3, 1'b1);
        1: set_config(7'd127, 16'hFFFF, 1'b1);
        2: set_config(7'd0, 16'd1, 1'b0);
        3: set_config(7'd1, 16'd0, 1'b1);
        4: set_config(7'($urandom_range(126, 1)), 16'($urandom_range(200, 1)), 1'b1);
        default: set_config(7'd64, 16'd20, 1'b1);
      endcase
      if (ph == 2) begin
        send_idle_pct = 65;
        recv_idle_pct = 28;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        squeeze <= 1'b1;
      end
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_nmt_slave_with_heartbeat: done, clean");
    end else begin
      $display("tb_nmt_slave_with_heartbeat: done, errors");
    end
    $finish;
  end

endmodule
